[sv/eaptlv_pkg.sv]
// ---------------------------------------------------------------------------
// EAP PDU TLV parser package
// Shared types and codes for the byte labeller and its configuration.
// ---------------------------------------------------------------------------
`default_nettype none

package eaptlv_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned LenW    = 16;
  localparam int unsigned OffW    = 10;
  localparam int unsigned CfgIdxW = 2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgIdxIdentity     = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgIdxNotification = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgIdxAkaPrime     = 2'd2;

  localparam logic [ByteW-1:0] RstTypeIdentity     = 8'd1;
  localparam logic [ByteW-1:0] RstTypeNotification = 8'd2;
  localparam logic [ByteW-1:0] RstTypeAkaPrime     = 8'd50;

  // parse phase, one-hot
  typedef enum logic [12:0] {
    PH_CODE = 13'b0_0000_0000_0001,
    PH_ID   = 13'b0_0000_0000_0010,
    PH_LHI  = 13'b0_0000_0000_0100,
    PH_LLO  = 13'b0_0000_0000_1000,
    PH_TYPE = 13'b0_0000_0001_0000,
    PH_SUB  = 13'b0_0000_0010_0000,
    PH_RS1  = 13'b0_0000_0100_0000,
    PH_RS2  = 13'b0_0000_1000_0000,
    PH_ATY  = 13'b0_0001_0000_0000,
    PH_ALEN = 13'b0_0010_0000_0000,
    PH_AVAL = 13'b0_0100_0000_0000,
    PH_RAW  = 13'b0_1000_0000_0000,
    PH_SKIP = 13'b1_0000_0000_0000
  } phase_e;

  typedef enum logic [3:0] {
    KIND_CODE      = 4'd0,
    KIND_ID        = 4'd1,
    KIND_LEN_HI    = 4'd2,
    KIND_LEN_LO    = 4'd3,
    KIND_TYPE      = 4'd4,
    KIND_SUBTYPE   = 4'd5,
    KIND_RESERVED  = 4'd6,
    KIND_ATTR_TYPE = 4'd7,
    KIND_ATTR_LEN  = 4'd8,
    KIND_ATTR_VAL  = 4'd9,
    KIND_RAW       = 4'd10
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_UNKNOWN  = 2'd1,
    ERR_OVERRUN  = 2'd2,
    ERR_ZERO_LEN = 2'd3
  } err_e;

  typedef struct packed {
    logic [ByteW-1:0] type_identity;
    logic [ByteW-1:0] type_notification;
    logic [ByteW-1:0] type_aka_prime;
  } cfg_t;

  typedef struct packed {
    logic [ByteW-1:0] data;
    kind_e            kind;
    logic [ByteW-1:0] attr_type;
    logic [OffW-1:0]  offset;
    logic             last;
    err_e             err;
  } res_t;

endpackage

`default_nettype wire

[sv/eaptlv_cfg_regs.sv]
// ---------------------------------------------------------------------------
// EAP PDU TLV parser configuration registers
// Holds the three EAP type codes; writes to unused indexes are dropped.
// ---------------------------------------------------------------------------
`default_nettype none

module eaptlv_cfg_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [eaptlv_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [eaptlv_pkg::ByteW-1:0]   cfg_data_i,
  output eaptlv_pkg::cfg_t                   cfg_o
);
  import eaptlv_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgIdxIdentity:     cfg_d.type_identity     = cfg_data_i;
        CfgIdxNotification: cfg_d.type_notification = cfg_data_i;
        CfgIdxAkaPrime:     cfg_d.type_aka_prime    = cfg_data_i;
        default:            cfg_d                   = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.type_identity     <= RstTypeIdentity;
      cfg_q.type_notification <= RstTypeNotification;
      cfg_q.type_aka_prime    <= RstTypeAkaPrime;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

[sv/eaptlv_core.sv]
// ---------------------------------------------------------------------------
// EAP PDU TLV parser core
// Parse state and per-byte labelling; the state advances on each transaction.
// ---------------------------------------------------------------------------
`default_nettype none

module eaptlv_core (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        fire_i,
  input  wire logic [eaptlv_pkg::ByteW-1:0] byte_i,
  input  wire logic                        sop_i,
  input  wire eaptlv_pkg::cfg_t            cfg_i,
  output eaptlv_pkg::res_t                 res_o
);
  import eaptlv_pkg::*;

  phase_e           phase_q, phase_d, cur;
  logic [LenW-1:0]  len_q, len_d;
  logic [LenW-1:0]  seen_q, seen_d;
  logic [OffW-1:0]  rem_q, rem_d;
  logic [ByteW-1:0] at_q, at_d;
  err_e             errl_q, errl_d;
  logic [OffW-1:0]  cnt_q, cnt_d;

  logic [LenW-1:0]  seen_inc;
  logic [LenW-1:0]  len_new;
  logic [LenW-1:0]  room;
  logic [OffW-1:0]  vlen;
  logic [OffW-1:0]  rem_dec;
  logic             last_body;
  logic             body;
  err_e             err;

  assign seen_inc  = seen_q + 16'd1;
  assign last_body = (seen_inc == len_q);
  assign len_new   = {len_q[LenW-1:ByteW], byte_i};
  assign room      = len_q - seen_inc;
  assign vlen      = {byte_i, 2'b00} - 10'd2;
  assign rem_dec   = (rem_q != '0) ? (rem_q - 10'd1) : rem_q;

  always_comb begin
    cur     = sop_i ? PH_CODE : phase_q;
    phase_d = phase_q;
    len_d   = len_q;
    seen_d  = seen_inc;
    rem_d   = rem_q;
    at_d    = at_q;
    errl_d  = errl_q;
    cnt_d   = cnt_q;
    body    = 1'b1;
    err     = ERR_NONE;

    res_o.data      = byte_i;
    res_o.kind      = KIND_RAW;
    res_o.attr_type = '0;
    res_o.offset    = '0;
    res_o.last      = last_body;

    unique case (cur)
      PH_CODE: begin
        body       = 1'b0;
        errl_d     = ERR_NONE;
        seen_d     = 16'd1;
        len_d      = '0;
        rem_d      = '0;
        at_d       = '0;
        cnt_d      = '0;
        res_o.kind = KIND_CODE;
        res_o.last = 1'b0;
        phase_d    = PH_ID;
      end
      PH_ID: begin
        body       = 1'b0;
        res_o.kind = KIND_ID;
        res_o.last = 1'b0;
        phase_d    = PH_LHI;
      end
      PH_LHI: begin
        body       = 1'b0;
        res_o.kind = KIND_LEN_HI;
        res_o.last = 1'b0;
        len_d      = {byte_i, 8'h00};
        phase_d    = PH_LLO;
      end
      PH_LLO: begin
        body       = 1'b0;
        res_o.kind = KIND_LEN_LO;
        len_d      = len_new;
        // short PDU ends at the header
        res_o.last = (len_new <= 16'd4);
        phase_d    = (len_new <= 16'd4) ? PH_CODE : PH_TYPE;
      end
      PH_TYPE: begin
        res_o.kind = KIND_TYPE;
        phase_d    = PH_TYPE;
        if (byte_i == cfg_i.type_aka_prime) begin
          if (last_body) err = ERR_OVERRUN;
          phase_d = PH_SUB;
        end else if (byte_i == cfg_i.type_notification ||
                     byte_i == cfg_i.type_identity) begin
          cnt_d   = '0;
          phase_d = PH_RAW;
        end else begin
          err = ERR_UNKNOWN;
        end
      end
      PH_SUB: begin
        res_o.kind = KIND_SUBTYPE;
        if (last_body) err = ERR_OVERRUN;
        phase_d = PH_RS1;
      end
      PH_RS1: begin
        res_o.kind = KIND_RESERVED;
        if (last_body) err = ERR_OVERRUN;
        phase_d = PH_RS2;
      end
      PH_RS2: begin
        res_o.kind = KIND_RESERVED;
        phase_d    = PH_ATY;
      end
      PH_ATY: begin
        res_o.kind      = KIND_ATTR_TYPE;
        res_o.attr_type = byte_i;
        at_d            = byte_i;
        if (last_body) err = ERR_OVERRUN;
        phase_d = PH_ALEN;
      end
      PH_ALEN: begin
        res_o.kind      = KIND_ATTR_LEN;
        res_o.attr_type = at_q;
        if (byte_i == '0) begin
          err = ERR_ZERO_LEN;
        end else if ({6'd0, vlen} > room) begin
          err = ERR_OVERRUN;
        end else begin
          rem_d   = vlen;
          cnt_d   = '0;
          phase_d = PH_AVAL;
        end
      end
      PH_AVAL: begin
        res_o.kind      = KIND_ATTR_VAL;
        res_o.attr_type = at_q;
        res_o.offset    = cnt_q;
        cnt_d           = cnt_q + 10'd1;
        rem_d           = rem_dec;
        if (rem_dec == '0) phase_d = PH_ATY;
      end
      PH_RAW: begin
        res_o.kind   = KIND_RAW;
        res_o.offset = cnt_q;
        cnt_d        = cnt_q + 10'd1;
      end
      default: begin
        // skip the rest of a failed PDU, repeating the latched error
        res_o.kind = KIND_RAW;
        err        = errl_q;
        phase_d    = PH_SKIP;
      end
    endcase

    if (body) begin
      if (err != ERR_NONE) begin
        errl_d  = err;
        phase_d = PH_SKIP;
      end
      if (last_body) phase_d = PH_CODE;
    end else begin
      if (cur != PH_CODE) seen_d = seen_inc;
    end

    res_o.err = err;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_CODE;
      len_q   <= '0;
      seen_q  <= '0;
      rem_q   <= '0;
      at_q    <= '0;
      errl_q  <= ERR_NONE;
      cnt_q   <= '0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      len_q   <= len_d;
      seen_q  <= seen_d;
      rem_q   <= rem_d;
      at_q    <= at_d;
      errl_q  <= errl_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

`default_nettype wire

[sv/eap_pdu_tlv_parser.sv]
// Result: the byte is labelled between the input register and the result register;
// it waits in the input register while the result register is full and not taken.
// Throughput: one byte per cycle unless the output stalls; the parse state updates in the cycle a byte
// leaves the input register.
// Reset: returns to expecting a code byte and reloads the type codes 1, 2, 50.
// ---------------------------------------------------------------------------
// EAP PDU TLV parser
// Labels each byte of an EAP PDU stream, parsing EAP-AKA' attributes.
// ---------------------------------------------------------------------------
`default_nettype none

module eap_pdu_tlv_parser (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [eaptlv_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [eaptlv_pkg::ByteW-1:0]   cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [eaptlv_pkg::ByteW-1:0]   in_byte_i,
  input  wire logic                          start_of_pdu_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [eaptlv_pkg::ByteW-1:0]        out_byte_o,
  output logic [3:0]                         field_kind_o,
  output logic [eaptlv_pkg::ByteW-1:0]        attr_type_o,
  output logic [eaptlv_pkg::OffW-1:0]         value_offset_o,
  output logic                               pdu_last_o,
  output logic [1:0]                         error_code_o
);
  import eaptlv_pkg::*;

  cfg_t             cfg;
  res_t             res;
  res_t             res_q;
  logic             in_vld_q, in_vld_d;
  logic [ByteW-1:0] in_byte_q;
  logic             in_sop_q;
  logic             out_vld_q, out_vld_d;
  logic             adv;
  logic             fire;
  logic             in_fire;

  eaptlv_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // result slot frees when empty or being taken
  assign adv        = !out_vld_q || out_ready_i;
  assign fire       = in_vld_q && adv;
  assign in_ready_o = !in_vld_q || adv;
  assign in_fire    = in_valid_i && in_ready_o;

  assign in_vld_d  = in_fire || (in_vld_q && !adv);
  assign out_vld_d = fire || (out_vld_q && !out_ready_i);

  eaptlv_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .byte_i (in_byte_q),
    .sop_i  (in_sop_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_byte_q <= in_byte_i;
      in_sop_q  <= start_of_pdu_i;
    end
    if (fire) begin
      res_q <= res;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign out_byte_o     = res_q.data;
  assign field_kind_o   = res_q.kind;
  assign attr_type_o    = res_q.attr_type;
  assign value_offset_o = res_q.offset;
  assign pdu_last_o     = res_q.last;
  assign error_code_o   = res_q.err;

endmodule

`default_nettype wire

[bench/testbench.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// EAP PDU TLV parser testbench
// Streams EAP PDU bytes into the parser with random gaps and output stalls,
// predicts the label of every byte and checks each result transaction field
// by field. A short table of hand-built PDUs runs first, then random PDUs
// under several type-code settings, the largest share of them well formed AKA' PDUs.
// ---------------------------------------------------------------------------

module testbench;
  import eaptlv_pkg::*;

  localparam logic [CfgIdxW-1:0] CfgIdxUnused = 2'd3;
  localparam int NumSettings = 5;
  localparam int BytesPerSetting = 90;
  localparam int LongRawBytes = 1100;
  localparam int HoldOffCycles = 400;
  localparam res_t NoLabel = '0;

  typedef struct packed {
    logic sop;
    logic [ByteW-1:0] data;
    logic typed;
    res_t want;
  } dir_row_t;

  // Hand-built PDUs: short length, unknown type, AKA' zero attribute length,
  // forced start over a PDU in progress. Untyped rows go through the predictor.
  localparam dir_row_t DirectedRows [26] = '{
    '{1'b1, 8'h01, 1'b1, '{8'h01, KIND_CODE,     8'h00, 10'd0, 1'b0, ERR_NONE}},
    '{1'b0, 8'hFF, 1'b1, '{8'hFF, KIND_ID,       8'h00, 10'd0, 1'b0, ERR_NONE}},
    '{1'b0, 8'h00, 1'b1, '{8'h00, KIND_LEN_HI,   8'h00, 10'd0, 1'b0, ERR_NONE}},
    '{1'b0, 8'h04, 1'b1, '{8'h04, KIND_LEN_LO,   8'h00, 10'd0, 1'b1, ERR_NONE}},
    '{1'b0, 8'h02, 1'b1, '{8'h02, KIND_CODE,     8'h00, 10'd0, 1'b0, ERR_NONE}},
    '{1'b0, 8'h00, 1'b1, '{8'h00, KIND_ID,       8'h00, 10'd0, 1'b0, ERR_NONE}},
    '{1'b0, 8'h00, 1'b1, '{8'h00, KIND_LEN_HI,   8'h00, 10'd0, 1'b0, ERR_NONE}},
    '{1'b0, 8'h06, 1'b1, '{8'h06, KIND_LEN_LO,   8'h00, 10'd0, 1'b0, ERR_NONE}},
    '{1'b0, 8'hFF, 1'b1, '{8'hFF, KIND_TYPE,     8'h00, 10'd0, 1'b0, ERR_UNKNOWN}},
    '{1'b0, 8'hAA, 1'b1, '{8'hAA, KIND_RAW,      8'h00, 10'd0, 1'b1, ERR_UNKNOWN}},
    '{1'b0, 8'h01, 1'b1, '{8'h01, KIND_CODE,     8'h00, 10'd0, 1'b0, ERR_NONE}},
    '{1'b0, 8'h80, 1'b1, '{8'h80, KIND_ID,       8'h00, 10'd0, 1'b0, ERR_NONE}},
    '{1'b0, 8'h00, 1'b1, '{8'h00, KIND_LEN_HI,   8'h00, 10'd0, 1'b0, ERR_NONE}},
    '{1'b0, 8'h0A, 1'b1, '{8'h0A, KIND_LEN_LO,   8'h00, 10'd0, 1'b0, ERR_NONE}},
    '{1'b0, 8'h32, 1'b0, NoLabel},
    '{1'b0, 8'h05, 1'b0, NoLabel},
    '{1'b0, 8'h00, 1'b0, NoLabel},
    '{1'b0, 8'h00, 1'b0, NoLabel},
    '{1'b0, 8'h01, 1'b0, NoLabel},
    '{1'b0, 8'h00, 1'b1, '{8'h00, KIND_ATTR_LEN, 8'h01, 10'd0, 1'b1, ERR_ZERO_LEN}},
    '{1'b0, 8'h01, 1'b1, '{8'h01, KIND_CODE,     8'h00, 10'd0, 1'b0, ERR_NONE}},
    '{1'b0, 8'h7F, 1'b1, '{8'h7F, KIND_ID,       8'h00, 10'd0, 1'b0, ERR_NONE}},
    '{1'b1, 8'h00, 1'b1, '{8'h00, KIND_CODE,     8'h00, 10'd0, 1'b0, ERR_NONE}},
    '{1'b0, 8'h01, 1'b1, '{8'h01, KIND_ID,       8'h00, 10'd0, 1'b0, ERR_NONE}},
    '{1'b0, 8'h00, 1'b1, '{8'h00, KIND_LEN_HI,   8'h00, 10'd0, 1'b0, ERR_NONE}},
    '{1'b0, 8'h00, 1'b1, '{8'h00, KIND_LEN_LO,   8'h00, 10'd0, 1'b1, ERR_NONE}}
  };

  // type codes per setting; the first one is the reset state
  localparam logic [ByteW-1:0] SetIdentity [NumSettings] = '{8'd1, 8'h00, 8'h33, 8'hFF, 8'h01};
  localparam logic [ByteW-1:0] SetNotify   [NumSettings] = '{8'd2, 8'hFF, 8'h33, 8'h00, 8'h02};
  localparam logic [ByteW-1:0] SetAka      [NumSettings] = '{8'd50, 8'h80, 8'h33, 8'h00, 8'hFF};

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [ByteW-1:0]   cfg_data_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [ByteW-1:0]   in_byte_i;
  logic               start_of_pdu_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [ByteW-1:0]   out_byte_o;
  logic [3:0]         field_kind_o;
  logic [ByteW-1:0]   attr_type_o;
  logic [OffW-1:0]    value_offset_o;
  logic               pdu_last_o;
  logic [1:0]         error_code_o;

  eap_pdu_tlv_parser dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_byte_i     (in_byte_i),
    .start_of_pdu_i(start_of_pdu_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_o    (out_byte_o),
    .field_kind_o  (field_kind_o),
    .attr_type_o   (attr_type_o),
    .value_offset_o(value_offset_o),
    .pdu_last_o    (pdu_last_o),
    .error_code_o  (error_code_o)
  );

  // parser state as predicted
  cfg_t             type_cfg;
  phase_e           parse_ph;
  logic [LenW-1:0]  pdu_len;
  logic [LenW-1:0]  seen;
  logic [OffW-1:0]  attr_left;
  logic [ByteW-1:0] cur_attr;
  err_e             err_hold;
  logic [OffW-1:0]  val_idx;

  res_t             pending_labels[$];
  logic [ByteW-1:0] pdu_bytes[$];
  int               attr_marks[$];

  bit steady;
  bit hold_req;
  bit hold_off;
  bit force_sop;
  int mismatch_count;
  int results_checked;
  int random_bytes;
  int pdus_sent;
  int errors_flagged;

  function automatic res_t label_byte(input logic [ByteW-1:0] b, input logic sop);
    res_t r;
    err_e err;
    logic at_end;
    int vlen;
    int room;
    r = '0;
    r.data = b;
    err = ERR_NONE;
    at_end = 1'b0;
    if (sop) parse_ph = PH_CODE;
    if (parse_ph == PH_CODE) begin
      err_hold = ERR_NONE;
      seen = 16'd1;
      pdu_len = '0;
      attr_left = '0;
      cur_attr = '0;
      val_idx = '0;
      r.kind = KIND_CODE;
      parse_ph = PH_ID;
    end else begin
      seen = seen + 16'd1;
      case (parse_ph)
        PH_ID: begin
          r.kind = KIND_ID;
          parse_ph = PH_LHI;
        end
        PH_LHI: begin
          r.kind = KIND_LEN_HI;
          pdu_len = {b, 8'h00};
          parse_ph = PH_LLO;
        end
        PH_LLO: begin
          r.kind = KIND_LEN_LO;
          pdu_len[7:0] = b;
          if (pdu_len <= 16'd4) begin
            at_end = 1'b1;
            parse_ph = PH_CODE;
          end else begin
            parse_ph = PH_TYPE;
          end
        end
        default: begin
          at_end = (seen == pdu_len);
          case (parse_ph)
            PH_TYPE: begin
              r.kind = KIND_TYPE;
              // AKA' wins over notification and identity, which are handled alike
              if (b == type_cfg.type_aka_prime) begin
                if (at_end) err = ERR_OVERRUN;
                parse_ph = PH_SUB;
              end else if (b == type_cfg.type_notification || b == type_cfg.type_identity) begin
                val_idx = '0;
                parse_ph = PH_RAW;
              end else begin
                err = ERR_UNKNOWN;
              end
            end
            PH_SUB: begin
              r.kind = KIND_SUBTYPE;
              if (at_end) err = ERR_OVERRUN;
              parse_ph = PH_RS1;
            end
            PH_RS1: begin
              r.kind = KIND_RESERVED;
              if (at_end) err = ERR_OVERRUN;
              parse_ph = PH_RS2;
            end
            PH_RS2: begin
              r.kind = KIND_RESERVED;
              parse_ph = PH_ATY;
            end
            PH_ATY: begin
              r.kind = KIND_ATTR_TYPE;
              cur_attr = b;
              r.attr_type = b;
              if (at_end) err = ERR_OVERRUN;
              parse_ph = PH_ALEN;
            end
            PH_ALEN: begin
              r.kind = KIND_ATTR_LEN;
              r.attr_type = cur_attr;
              if (b == 8'h00) begin
                err = ERR_ZERO_LEN;
              end else begin
                vlen = 4 * int'(b) - 2;
                room = int'(pdu_len) - int'(seen);
                if (vlen > room) begin
                  err = ERR_OVERRUN;
                end else begin
                  attr_left = OffW'(vlen);
                  val_idx = '0;
                  parse_ph = PH_AVAL;
                end
              end
            end
            PH_AVAL: begin
              r.kind = KIND_ATTR_VAL;
              r.attr_type = cur_attr;
              r.offset = val_idx;
              val_idx = val_idx + 1'b1;
              if (attr_left != '0) attr_left = attr_left - 1'b1;
              if (attr_left == '0) parse_ph = PH_ATY;
            end
            PH_RAW: begin
              r.kind = KIND_RAW;
              r.offset = val_idx;
              val_idx = val_idx + 1'b1;
            end
            default: begin
              // skip the rest of a failed PDU, repeating its error
              r.kind = KIND_RAW;
              err = err_hold;
              parse_ph = PH_SKIP;
            end
          endcase
          if (err != ERR_NONE) begin
            err_hold = err;
            parse_ph = PH_SKIP;
          end
          if (at_end) parse_ph = PH_CODE;
        end
      endcase
    end
    r.last = at_end;
    r.err = err;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(11, 30);
  endfunction

  function automatic logic [ByteW-1:0] unknown_type();
    logic [ByteW-1:0] t;
    do begin
      t = ByteW'($urandom);
    end while (t == type_cfg.type_identity || t == type_cfg.type_notification ||
               t == type_cfg.type_aka_prime);
    return t;
  endfunction

  task automatic note_mismatch(input string what, input logic [15:0] got,
                               input logic [15:0] want);
    mismatch_count++;
    if (mismatch_count <= 40)
      $display("mismatch at result %0d: %s got 0x%0h, want 0x%0h",
               results_checked, what, got, want);
  endtask

  // Offer one byte; returns at the falling edge after the transaction with
  // valid still high, so the next call can follow without a bubble.
  task automatic offer_byte(input logic sop, input logic [ByteW-1:0] data,
                            input logic typed, input res_t typed_want);
    int gap;
    res_t predicted;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    in_byte_i      <= data;
    start_of_pdu_i <= sop;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = label_byte(data, sop);
    pending_labels.push_back(typed ? typed_want : predicted);
    if (predicted.err != ERR_NONE && predicted.kind != KIND_RAW) errors_flagged++;
    @(negedge clk_i);
  endtask

  task automatic put_type_code(input logic [CfgIdxW-1:0] idx, input logic [ByteW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CfgIdxIdentity:     type_cfg.type_identity     = value;
      CfgIdxNotification: type_cfg.type_notification = value;
      CfgIdxAkaPrime:     type_cfg.type_aka_prime    = value;
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  // drop valid and let every pending label come back, plus the pipeline depth
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_labels.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic start_pdu(input logic [ByteW-1:0] eap_type);
    pdu_bytes.delete();
    attr_marks.delete();
    pdu_bytes.push_back(ByteW'($urandom));
    pdu_bytes.push_back(ByteW'($urandom));
    pdu_bytes.push_back(8'h00);
    pdu_bytes.push_back(8'h00);
    pdu_bytes.push_back(eap_type);
  endtask

  task automatic stamp_length();
    logic [LenW-1:0] total;
    total = LenW'(pdu_bytes.size());
    pdu_bytes[2] = total[15:8];
    pdu_bytes[3] = total[7:0];
  endtask

  task automatic make_aka();
    int r;
    int units;
    start_pdu(type_cfg.type_aka_prime);
    repeat (3) pdu_bytes.push_back(ByteW'($urandom));
    repeat ($urandom_range(0, 4)) begin
      r = $urandom_range(0, 99);
      units = (r < 75) ? $urandom_range(1, 3) : (r < 95) ? $urandom_range(4, 8)
                                                         : $urandom_range(9, 40);
      attr_marks.push_back(pdu_bytes.size());
      pdu_bytes.push_back(ByteW'($urandom));
      pdu_bytes.push_back(ByteW'(units));
      repeat (4 * units - 2) pdu_bytes.push_back(ByteW'($urandom));
    end
    stamp_length();
  endtask

  task automatic send_pdu(input logic first_sop, input logic noisy);
    foreach (pdu_bytes[i]) begin
      offer_byte((i == 0) ? first_sop : (noisy && $urandom_range(0, 7) == 0),
                 pdu_bytes[i], 1'b0, NoLabel);
      random_bytes++;
    end
  endtask

  task automatic random_pdu();
    int shape;
    int cut;
    int pick;
    logic first_sop;
    logic noisy;
    first_sop = force_sop || ($urandom_range(0, 3) != 0);
    force_sop = 1'b0;
    noisy = 1'b0;
    steady = ($urandom_range(0, 4) == 0);
    shape = $urandom_range(0, 99);
    if (shape < 40) begin
      make_aka();
    end else if (shape < 55) begin
      start_pdu($urandom_range(0, 1) ? type_cfg.type_identity : type_cfg.type_notification);
      repeat ($urandom_range(0, 12)) pdu_bytes.push_back(ByteW'($urandom));
      stamp_length();
    end else if (shape < 65) begin
      make_aka();
      pick = (attr_marks.size() > 0) ? attr_marks[$urandom_range(0, attr_marks.size() - 1)]
                                     : -1;
      case ($urandom_range(0, 2))
        0: if (pick >= 0) pdu_bytes[pick + 1] = 8'h00;
        1: if (pick >= 0)
             pdu_bytes[pick + 1] = ByteW'($urandom_range(pdu_bytes[pick + 1] + 1, 255));
        default: begin
          // shorten the length so the PDU ends in the header or on an attribute
          case ($urandom_range(0, 2))
            0: cut = $urandom_range(5, 7);
            1: cut = (pick >= 0) ? pick + 1 : 7;
            default: cut = $urandom_range(5, pdu_bytes.size() - 1);
          endcase
          pdu_bytes[2] = 8'h00;
          pdu_bytes[3] = ByteW'(cut);
          if ($urandom_range(0, 3) != 0)
            while (pdu_bytes.size() > cut) void'(pdu_bytes.pop_back());
        end
      endcase
    end else if (shape < 75) begin
      start_pdu(unknown_type());
      repeat ($urandom_range(0, 6)) pdu_bytes.push_back(ByteW'($urandom));
      stamp_length();
    end else if (shape < 85) begin
      pdu_bytes.delete();
      pdu_bytes.push_back(ByteW'($urandom));
      pdu_bytes.push_back(ByteW'($urandom));
      pdu_bytes.push_back(8'h00);
      pdu_bytes.push_back(ByteW'($urandom_range(0, 4)));
    end else if (shape < 90) begin
      pdu_bytes.delete();
      repeat ($urandom_range(1, 8)) pdu_bytes.push_back(ByteW'($urandom));
      noisy = 1'b1;
    end else begin
      // abandon partway; the next PDU forces a new start
      make_aka();
      while (pdu_bytes.size() > 1 && $urandom_range(0, 3) != 0) void'(pdu_bytes.pop_back());
      force_sop = 1'b1;
    end
    send_pdu(first_sop, noisy);
    pdus_sent++;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #(4_000_000);
    $display("RESULT: ERROR");
    $finish;
  end

  // long output stall while the source keeps offering bytes
  initial begin
    hold_off = 1'b0;
    wait (hold_req);
    hold_off = 1'b1;
    repeat (HoldOffCycles) @(posedge clk_i);
    hold_off = 1'b0;
  end

  initial begin : sink_pacing
    int run_left;
    int stall_left;
    run_left = 0;
    stall_left = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(negedge clk_i);
      if (run_left == 0 && stall_left == 0) begin
        run_left = ($urandom_range(0, 99) < 20) ? $urandom_range(20, 80) : $urandom_range(1, 6);
        stall_left = pick_gap();
      end
      if (hold_off) begin
        out_ready_i <= 1'b0;
      end else if (run_left > 0) begin
        out_ready_i <= 1'b1;
        run_left--;
      end else begin
        out_ready_i <= 1'b0;
        stall_left--;
      end
    end
  end

  always @(posedge clk_i) begin : check_labels
    res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_checked++;
      if (pending_labels.size() == 0) begin
        note_mismatch("result with nothing pending", out_byte_o, 16'h0);
      end else begin
        want = pending_labels.pop_front();
        if (out_byte_o !== want.data) note_mismatch("out_byte", out_byte_o, want.data);
        if (field_kind_o !== want.kind) note_mismatch("field_kind", field_kind_o, want.kind);
        if (attr_type_o !== want.attr_type)
          note_mismatch("attr_type", attr_type_o, want.attr_type);
        if (value_offset_o !== want.offset)
          note_mismatch("value_offset", value_offset_o, want.offset);
        if (pdu_last_o !== want.last) note_mismatch("pdu_last", pdu_last_o, want.last);
        if (error_code_o !== want.err) note_mismatch("error_code", error_code_o, want.err);
      end
    end
  end

  initial begin : stimulus
    int target;
    rst_ni         <= 1'b0;
    cfg_valid_i    <= 1'b0;
    cfg_index_i    <= CfgIdxIdentity;
    cfg_data_i     <= '0;
    in_valid_i     <= 1'b0;
    in_byte_i      <= '0;
    start_of_pdu_i <= 1'b0;
    type_cfg = {RstTypeIdentity, RstTypeNotification, RstTypeAkaPrime};
    parse_ph = PH_CODE;
    pdu_len = '0;
    seen = '0;
    attr_left = '0;
    cur_attr = '0;
    err_hold = ERR_NONE;
    val_idx = '0;
    steady = 1'b0;
    hold_req = 1'b0;
    force_sop = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (DirectedRows[i])
      offer_byte(DirectedRows[i].sop, DirectedRows[i].data, DirectedRows[i].typed,
                 DirectedRows[i].want);

    for (int s = 0; s < NumSettings; s++) begin
      if (s != 0) begin
        wait_drained();
        put_type_code(CfgIdxIdentity, SetIdentity[s]);
        put_type_code(CfgIdxNotification, SetNotify[s]);
        put_type_code(CfgIdxAkaPrime, SetAka[s]);
        if (s == 2) put_type_code(CfgIdxUnused, 8'h55);
        cfg_valid_i <= 1'b0;
      end
      if (s == 0) hold_req = 1'b1;
      target = random_bytes + BytesPerSetting;
      while (random_bytes < target) random_pdu();
      if (s == 0) begin
        // identity payload long enough to wrap the offset counter
        steady = 1'b0;
        start_pdu(type_cfg.type_identity);
        repeat (LongRawBytes) pdu_bytes.push_back(ByteW'($urandom));
        stamp_length();
        send_pdu(1'b1, 1'b0);
        pdus_sent++;
      end
    end

    wait_drained();
    $display("Checked %0d labelled bytes from %0d random PDUs plus a directed table,",
             results_checked, pdus_sent);
    $display("%0d with a parse error, over %0d type-code settings, an offset wrap",
             errors_flagged, NumSettings);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
